### src/sam_pkg.sv
// Package for the stack allocator: constants, status and command codes, types.
package sam_pkg;
  localparam int unsigned MaxBlocksDef = 64;
  localparam int unsigned LineBytesDef = 64;
  localparam logic [31:0] PoolReset = 32'd1048576;

  typedef enum logic [1:0] {
    CmdAlloc  = 2'd0,
    CmdFree   = 2'd1,
    CmdResize = 2'd2,
    CmdQuery  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StNoMem    = 3'd2,
    StNotFound = 3'd3,
    StNotLast  = 3'd4,
    StNonMov   = 3'd5,
    StEmpty    = 3'd6
  } status_e;

  localparam logic KindPrimary = 1'b0;
  localparam logic KindReloc   = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] size_bytes;
    logic [31:0] block_offset;
    logic        movable;
    logic        generic;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        record_kind;
    logic [31:0] block_offset_out;
    logic [31:0] old_offset;
    logic [5:0]  block_index;
    logic [31:0] free_bytes_out;
    logic [31:0] peak_bytes;
    logic [31:0] peak_bytes_no_generic;
    logic        last;
  } out_word_t;
endpackage

### src/sam_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module sam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/stack_allocator_movable_blocks.sv
// Top level of the stack allocator with compaction.
// One command word at a time; s_axis_tready is high only while the sequencer is idle.
// Query passes SRead and SDecide to SPrim, which loads its word; allocate adds SApply.
// An error found at the top of the table goes from SDecide to SErr, which emits it.
// The table is kept in three RAMs with a shared read address and registered reads.
// On a top match, free and resize pass SCheck and SApply to SPrim and its primary word.
// A movable search walks from the top down at one entry per cycle. The entries
// passed on the way are exactly the later blocks, so their movable flags are
// checked on the way. Each relocation word then passes SRelRd to read its entry
// and SRelOut to emit the word and rewrite the entry, waiting for m_axis_tready.
// A pool_bytes write is taken only when idle with no word pending, and empties
// the table at once.
module stack_allocator_movable_blocks #(
  parameter int unsigned MAX_BLOCKS = sam_pkg::MaxBlocksDef,
  parameter int unsigned LINE_BYTES = sam_pkg::LineBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: command[1:0], size_bytes[33:2], block_offset[65:34], movable[66],
  //        generic[67], zero pad to 72
  input  logic [71:0]  s_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], block_offset_out[34:3], old_offset[66:35],
  //        block_index[72:67], free_bytes_out[104:73], peak_bytes[136:105],
  //        peak_bytes_no_generic[168:137], zero pad to 176
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tuser,   // record_kind
  output logic         m_axis_tlast    // last
);
  import sam_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LB = $clog2(LINE_BYTES);

  typedef enum logic [9:0] {
    SIdle   = 10'b0000000001,
    SRead   = 10'b0000000010,
    SDecide = 10'b0000000100,
    SSearch = 10'b0000001000,
    SCheck  = 10'b0000010000,
    SApply  = 10'b0000100000,
    SPrim   = 10'b0001000000,
    SRelRd  = 10'b0010000000,
    SRelOut = 10'b0100000000,
    SErr    = 10'b1000000000
  } state_e;

  state_e state_q;
  in_word_t in_q;
  logic [31:0] pool_q, free_q, alloc_q, gen_q, peak_q, peakng_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] ptr_q, nr_q, end_q;
  status_e err_q;
  logic [32:0] req_q;
  logic [31:0] oldsz_q, poff_q, delta_q;
  logic shrink_q, allmov_q, pgen_q, reloc_q;
  out_word_t ow_q, ow_d;
  logic ov_q;
  logic load_w;

  // table RAMs: offset, size, {movable, generic}
  logic        we_off, we_sz, we_fl;
  logic [IW-1:0] wa_off, wa_sz, wa_fl, ra;
  logic [31:0] wd_off, wd_sz, rd_off, rd_sz;
  logic [1:0]  wd_fl, rd_fl;

  sam_ram #(.Width(32), .Depth(MAX_BLOCKS)) u_off (
    .clk_i, .we_i(we_off), .waddr_i(wa_off), .wdata_i(wd_off), .raddr_i(ra),
    .rdata_o(rd_off));
  sam_ram #(.Width(32), .Depth(MAX_BLOCKS)) u_sz (
    .clk_i, .we_i(we_sz), .waddr_i(wa_sz), .wdata_i(wd_sz), .raddr_i(ra),
    .rdata_o(rd_sz));
  sam_ram #(.Width(2), .Depth(MAX_BLOCKS)) u_fl (
    .clk_i, .we_i(we_fl), .waddr_i(wa_fl), .wdata_i(wd_fl), .raddr_i(ra),
    .rdata_o(rd_fl));

  in_word_t s_word;
  assign s_word.command      = s_axis_tdata[1:0];
  assign s_word.size_bytes   = s_axis_tdata[33:2];
  assign s_word.block_offset = s_axis_tdata[65:34];
  assign s_word.movable      = s_axis_tdata[66];
  assign s_word.generic      = s_axis_tdata[67];

  // rounded request, 33 bits
  logic [32:0] req_rnd;
  always_comb begin
    req_rnd = {1'b0, s_word.size_bytes[31:LB], {LB{1'b0}}};
    if (s_word.size_bytes[LB-1:0] != '0) begin
      req_rnd = req_rnd + 33'(LINE_BYTES);
    end
    if (req_rnd == '0) begin
      req_rnd = 33'(LINE_BYTES);
    end
  end

  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o   = (state_q == SIdle) && !ov_q;
  wire s_acc   = s_axis_tvalid && s_axis_tready;
  wire cfg_acc = cfg_valid_i && cfg_ready_o;
  wire m_acc   = m_axis_tvalid && m_axis_tready;
  wire out_free = !ov_q || m_axis_tready;

  wire [IW-1:0] top_idx = IW'(cnt_q - CW'(1));
  wire [32:0] avail = {1'b0, free_q} + {1'b0, oldsz_q};
  wire [31:0] alloc_add = alloc_q + req_q[31:0];
  wire [31:0] alloc_rs = alloc_q - oldsz_q + req_q[31:0];
  wire [31:0] ng_new = (alloc_q - gen_q) + (in_q.generic ? 32'd0 : req_q[31:0]);
  wire req_lt = req_q[31:0] < oldsz_q;

  // shared ALU: relocation offset
  wire [31:0] reloc_off = shrink_q ? rd_off - delta_q : rd_off + delta_q;

  always_comb begin
    we_off = 1'b0; we_sz = 1'b0; we_fl = 1'b0;
    wa_off = ptr_q; wa_sz = ptr_q; wa_fl = ptr_q;
    wd_off = reloc_off; wd_sz = rd_sz; wd_fl = rd_fl;
    ra = ptr_q;
    load_w = 1'b0;
    ow_d = '{status: StOk, record_kind: KindPrimary, block_offset_out: poff_q,
             old_offset: '0, block_index: 6'(nr_q), free_bytes_out: free_q,
             peak_bytes: peak_q, peak_bytes_no_generic: peakng_q, last: !reloc_q};
    case (state_q)
      SDecide, SSearch: ra = IW'(ptr_q - IW'(1));
      SApply: begin
        if (in_q.command == CmdAlloc) begin
          we_off = 1'b1; we_sz = 1'b1; we_fl = 1'b1;
          wa_off = IW'(cnt_q); wa_sz = wa_off; wa_fl = wa_off;
          wd_off = pool_q - free_q; wd_sz = req_q[31:0];
          wd_fl = {in_q.movable, in_q.generic};
        end else if (in_q.command == CmdResize) begin
          we_sz = 1'b1; wa_sz = nr_q; wd_sz = req_q[31:0];
        end
      end
      SPrim: load_w = out_free;
      SRelOut: begin
        load_w = out_free;
        ow_d.record_kind = KindReloc;
        ow_d.block_offset_out = reloc_off;
        ow_d.old_offset = rd_off;
        ow_d.last = (ptr_q == end_q);
        if (in_q.command == CmdFree) begin
          ow_d.block_index = 6'(IW'(ptr_q - IW'(1)));
          if (out_free) begin
            we_off = 1'b1; we_sz = 1'b1; we_fl = 1'b1;
            wa_off = IW'(ptr_q - IW'(1)); wa_sz = wa_off; wa_fl = wa_off;
          end
        end else begin
          ow_d.block_index = 6'(ptr_q);
          we_off = out_free;
        end
      end
      SErr: begin
        load_w = out_free;
        ow_d.status = err_q;
        ow_d.block_offset_out = '0;
        ow_d.block_index = '0;
        ow_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      in_q <= '0; req_q <= '0;
      pool_q <= PoolReset; free_q <= PoolReset;
      alloc_q <= '0; gen_q <= '0; peak_q <= '0; peakng_q <= '0;
      cnt_q <= '0; ptr_q <= '0; nr_q <= '0; end_q <= '0; err_q <= StOk;
      oldsz_q <= '0; poff_q <= '0; delta_q <= '0;
      shrink_q <= 1'b0; allmov_q <= 1'b0; pgen_q <= 1'b0; reloc_q <= 1'b0;
      ow_q <= '0; ov_q <= 1'b0;
    end else begin
      if (load_w) begin
        ow_q <= ow_d; ov_q <= 1'b1;
      end else if (m_acc) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (cfg_acc) begin
            pool_q <= cfg_data_i; free_q <= cfg_data_i;
            alloc_q <= '0; gen_q <= '0; peak_q <= '0; peakng_q <= '0; cnt_q <= '0;
          end
          if (s_acc) begin
            in_q <= s_word; req_q <= req_rnd; ptr_q <= top_idx;
            state_q <= SRead;
          end
        end
        SRead: state_q <= SDecide;
        SDecide: begin
          // rd_* holds the top entry
          nr_q <= top_idx; end_q <= top_idx; reloc_q <= 1'b0;
          oldsz_q <= rd_sz; poff_q <= rd_off; pgen_q <= rd_fl[0];
          if (in_q.command == CmdAlloc) begin
            if (cnt_q >= CW'(MAX_BLOCKS)) begin
              err_q <= StFull; state_q <= SErr;
            end else if (req_q > {1'b0, free_q}) begin
              err_q <= StNoMem; state_q <= SErr;
            end else begin
              state_q <= SApply;
            end
          end else if (cnt_q == '0) begin
            err_q <= StEmpty; state_q <= SErr;
          end else if (in_q.command == CmdQuery) begin
            state_q <= SPrim;
          end else if (rd_off == in_q.block_offset) begin
            allmov_q <= 1'b1; state_q <= SCheck;
          end else if (!in_q.movable) begin
            err_q <= StNotLast; state_q <= SErr;
          end else if (top_idx == '0) begin
            err_q <= StNotFound; state_q <= SErr;
          end else begin
            allmov_q <= rd_fl[1]; ptr_q <= IW'(ptr_q - IW'(1));
            state_q <= SSearch;
          end
        end
        SSearch: begin
          if (rd_off == in_q.block_offset) begin
            nr_q <= ptr_q; oldsz_q <= rd_sz; poff_q <= rd_off; pgen_q <= rd_fl[0];
            state_q <= SCheck;
          end else if (ptr_q == '0) begin
            err_q <= StNotFound; state_q <= SErr;
          end else begin
            allmov_q <= allmov_q & rd_fl[1]; ptr_q <= IW'(ptr_q - IW'(1));
          end
        end
        SCheck: begin
          if (!allmov_q) begin
            err_q <= StNonMov; state_q <= SErr;
          end else if (in_q.command == CmdResize && pgen_q) begin
            err_q <= StEmpty; state_q <= SErr;
          end else if (in_q.command == CmdResize && req_q > avail) begin
            err_q <= StNoMem; state_q <= SErr;
          end else begin
            state_q <= SApply;
          end
        end
        SApply: begin
          state_q <= SPrim;
          ptr_q <= IW'(nr_q + IW'(1));
          if (in_q.command == CmdAlloc) begin
            poff_q <= pool_q - free_q; nr_q <= IW'(cnt_q);
            free_q <= free_q - req_q[31:0];
            alloc_q <= alloc_add;
            if (in_q.generic) gen_q <= gen_q + req_q[31:0];
            if (ng_new > peakng_q) peakng_q <= ng_new;
            if (alloc_add > peak_q) peak_q <= alloc_add;
            cnt_q <= cnt_q + CW'(1);
          end else if (in_q.command == CmdFree) begin
            free_q <= free_q + oldsz_q;
            alloc_q <= alloc_q - oldsz_q;
            if (pgen_q) gen_q <= gen_q - oldsz_q;
            cnt_q <= cnt_q - CW'(1);
            delta_q <= oldsz_q; shrink_q <= 1'b1;
            reloc_q <= (nr_q != end_q);
          end else begin
            free_q <= avail[31:0] - req_q[31:0];
            alloc_q <= alloc_rs;
            if (alloc_rs > peak_q) peak_q <= alloc_rs;
            shrink_q <= req_lt;
            delta_q <= req_lt ? oldsz_q - req_q[31:0] : req_q[31:0] - oldsz_q;
            reloc_q <= (nr_q != end_q) && (req_q[31:0] != oldsz_q);
          end
        end
        SPrim: if (out_free) begin
          state_q <= reloc_q ? SRelRd : SIdle;
        end
        SRelRd: state_q <= SRelOut;
        SRelOut: if (out_free) begin
          if (ptr_q == end_q) begin
            state_q <= SIdle;
          end else begin
            ptr_q <= IW'(ptr_q + IW'(1)); state_q <= SRelRd;
          end
        end
        SErr: if (out_free) begin
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, ow_q.peak_bytes_no_generic, ow_q.peak_bytes,
                          ow_q.free_bytes_out, ow_q.block_index, ow_q.old_offset,
                          ow_q.block_offset_out, ow_q.status};
  assign m_axis_tuser  = ow_q.record_kind;
  assign m_axis_tlast  = ow_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_BLOCKS)) else $error("block count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast})))
    else $error("word dropped or changed");
endmodule
